[rtl/cfdp_pkg.sv]
// Package: shared types and constants for the CFDP PDU header parser.
package cfdp_pkg;

   // Bytes in the fixed part of the header
   localparam logic [4:0] FIXED_BYTES = 5'd4;
   // Smallest header: fixed part, two 1-byte entities and a 1-byte sequence number
   localparam logic [4:0] MIN_HEADER_BYTES = 5'd7;

   // Result status codes
   localparam logic STATUS_DECODED   = 1'b0;
   localparam logic STATUS_TRUNCATED = 1'b1;

   // One input beat
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } beat_type;

   // One decoded result
   typedef struct packed {
      logic        parse_status;
      logic [2:0]  version;
      logic [4:0]  flag_bits;
      logic [15:0] data_field_length;
      logic        segmentation_control;
      logic [2:0]  entity_length_code;
      logic        segment_metadata_flag;
      logic [2:0]  sequence_length_code;
      logic [63:0] source_entity;
      logic [63:0] transaction_number;
      logic [63:0] dest_entity;
      logic [4:0]  header_length;
   } hdr_result_type;

   // Header length in bytes from the two length codes: 4 + 2*(e+1) + (s+1)
   function automatic logic [4:0] header_bytes(input logic [2:0] ecode,
                                               input logic [2:0] scode);
      header_bytes = MIN_HEADER_BYTES + {1'b0, ecode, 1'b0} + {2'b00, scode};
   endfunction

endpackage

[rtl/cfdp_hdr_decode.sv]
// Header decode state: byte position, field accumulators and skip flag.
module cfdp_hdr_decode (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  cfdp_pkg::beat_type      beat,
   output logic                    produce,
   output cfdp_pkg::hdr_result_type result
);
   import cfdp_pkg::*;

   logic [4:0]  pos_ff,   pos_in;
   logic        skip_ff,  skip_in;
   logic [31:0] fixed_ff, fixed_in;
   logic [63:0] src_ff,   src_in;
   logic [63:0] seq_ff,   seq_in;
   logic [63:0] dst_ff,   dst_in;

   logic [31:0] fixed_nxt;
   logic [63:0] src_nxt, seq_nxt, dst_nxt;
   logic [4:0]  src_end, seq_end, pos_inc, hlen;
   logic        done, trunc;

   always_comb begin
      // Field boundaries from the length codes already held
      src_end = FIXED_BYTES + {2'b00, fixed_ff[6:4]} + 5'd1;
      seq_end = src_end + {2'b00, fixed_ff[2:0]} + 5'd1;

      fixed_nxt = fixed_ff;
      src_nxt   = src_ff;
      seq_nxt   = seq_ff;
      dst_nxt   = dst_ff;
      if (pos_ff < FIXED_BYTES) begin
         fixed_nxt = {fixed_ff[23:0], beat.data_byte};
      end else if (pos_ff < src_end) begin
         src_nxt = {src_ff[55:0], beat.data_byte};
      end else if (pos_ff < seq_end) begin
         seq_nxt = {seq_ff[55:0], beat.data_byte};
      end else begin
         dst_nxt = {dst_ff[55:0], beat.data_byte};
      end

      pos_inc = pos_ff + 5'd1;
      hlen    = header_bytes(fixed_nxt[6:4], fixed_nxt[2:0]);
      done    = !skip_ff && (pos_inc > FIXED_BYTES) && (pos_inc == hlen);
      trunc   = !skip_ff && !done && beat.last_byte;
      produce = done || trunc;

      result = '0;
      if (trunc) begin
         result.parse_status = STATUS_TRUNCATED;
      end else begin
         result.parse_status          = STATUS_DECODED;
         result.version               = fixed_nxt[31:29];
         result.flag_bits             = fixed_nxt[28:24];
         result.data_field_length     = fixed_nxt[23:8];
         result.segmentation_control  = fixed_nxt[7];
         result.entity_length_code    = fixed_nxt[6:4];
         result.segment_metadata_flag = fixed_nxt[3];
         result.sequence_length_code  = fixed_nxt[2:0];
         result.source_entity         = src_nxt;
         result.transaction_number    = seq_nxt;
         result.dest_entity           = dst_nxt;
         result.header_length         = hlen;
      end

      // Next state
      pos_in   = pos_inc;
      skip_in  = skip_ff;
      fixed_in = fixed_nxt;
      src_in   = src_nxt;
      seq_in   = seq_nxt;
      dst_in   = dst_nxt;
      if (skip_ff || done || trunc) begin
         pos_in   = '0;
         fixed_in = '0;
         src_in   = '0;
         seq_in   = '0;
         dst_in   = '0;
      end
      if (skip_ff) begin
         skip_in = !beat.last_byte;
         if (!beat.last_byte) begin
            pos_in   = pos_ff;
            fixed_in = fixed_ff;
            src_in   = src_ff;
            seq_in   = seq_ff;
            dst_in   = dst_ff;
         end
      end else if (done) begin
         skip_in = !beat.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         skip_ff  <= 1'b0;
         fixed_ff <= '0;
         src_ff   <= '0;
         seq_ff   <= '0;
         dst_ff   <= '0;
      end else if (step) begin
         pos_ff   <= pos_in;
         skip_ff  <= skip_in;
         fixed_ff <= fixed_in;
         src_ff   <= src_in;
         seq_ff   <= seq_in;
         dst_ff   <= dst_in;
      end
   end

endmodule

[rtl/cfdp_pdu_header_parser.sv]
// Top level of the CFDP PDU header parser: input register, decode, result register.
//
//   channel | direction | handshake         | beat contents
//   --------+-----------+-------------------+-------------------------------------
//   req_    | in        | req_valid/stall   | one PDU byte and its last-byte flag
//   rsp_    | out       | rsp_valid/stall   | decoded header or truncation status
//
// One byte a cycle sustained while no stalled result holds it up; a beat waits in the
// input register and is decoded as it moves into the result register, so a result is
// shown after the byte completing the header (or the early last byte) passes both.
// Synchronous active-high reset clears the position count, skip flag, accumulators
// and both valid flags.
// A stalled result only holds up bytes that would make a new result; other bytes
// keep flowing through the decode state.
module cfdp_pdu_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_parse_status,
   output logic [2:0]  rsp_version,
   output logic [4:0]  rsp_flag_bits,
   output logic [15:0] rsp_data_field_length,
   output logic        rsp_segmentation_control,
   output logic [2:0]  rsp_entity_length_code,
   output logic        rsp_segment_metadata_flag,
   output logic [2:0]  rsp_sequence_length_code,
   output logic [63:0] rsp_source_entity,
   output logic [63:0] rsp_transaction_number,
   output logic [63:0] rsp_dest_entity,
   output logic [4:0]  rsp_header_length
);
   import cfdp_pkg::*;

   // Input register
   logic           in_valid_ff;
   beat_type       in_beat_ff;

   // Result register
   logic           out_valid_ff, out_valid_in;
   hdr_result_type out_result_ff;

   logic           out_free;
   logic           fire;
   logic           produce;
   hdr_result_type result;

   cfdp_hdr_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (fire),
      .beat    (in_beat_ff),
      .produce (produce),
      .result  (result)
   );

   // The result register can take a beat when empty or being drained this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   // Advance the held byte unless it makes a result that has nowhere to go
   assign fire      = in_valid_ff && (out_free || !produce);
   assign req_stall = in_valid_ff && !fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_beat_ff.data_byte <= req_data_byte;
         in_beat_ff.last_byte <= req_last_byte;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = fire && produce;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Load the payload only when a new result is taken in
   always_ff @(posedge clock) begin
      if (fire && produce) begin
         out_result_ff <= result;
      end
   end

   assign rsp_valid                 = out_valid_ff;
   assign rsp_parse_status          = out_result_ff.parse_status;
   assign rsp_version               = out_result_ff.version;
   assign rsp_flag_bits             = out_result_ff.flag_bits;
   assign rsp_data_field_length     = out_result_ff.data_field_length;
   assign rsp_segmentation_control  = out_result_ff.segmentation_control;
   assign rsp_entity_length_code    = out_result_ff.entity_length_code;
   assign rsp_segment_metadata_flag = out_result_ff.segment_metadata_flag;
   assign rsp_sequence_length_code  = out_result_ff.sequence_length_code;
   assign rsp_source_entity         = out_result_ff.source_entity;
   assign rsp_transaction_number    = out_result_ff.transaction_number;
   assign rsp_dest_entity           = out_result_ff.dest_entity;
   assign rsp_header_length         = out_result_ff.header_length;

endmodule

[rtl/cfdp_hdr_checker.sv]
// Port-level checker for the CFDP PDU header parser, with its bind.
module cfdp_hdr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_data_byte,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_parse_status,
   input logic [2:0]  rsp_version,
   input logic [4:0]  rsp_flag_bits,
   input logic [15:0] rsp_data_field_length,
   input logic        rsp_segmentation_control,
   input logic [2:0]  rsp_entity_length_code,
   input logic        rsp_segment_metadata_flag,
   input logic [2:0]  rsp_sequence_length_code,
   input logic [63:0] rsp_source_entity,
   input logic [63:0] rsp_transaction_number,
   input logic [63:0] rsp_dest_entity,
   input logic [4:0]  rsp_header_length
);
   import cfdp_pkg::*;

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_header_length)
         && $stable(rsp_parse_status) && $stable(rsp_dest_entity))
      else $error("stalled result beat changed");

   // Decoded header length agrees with its own length codes
   a_hlen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_parse_status == STATUS_DECODED) |->
         rsp_header_length == header_bytes(rsp_entity_length_code,
                                           rsp_sequence_length_code))
      else $error("header length does not match length codes");

   // Truncation beats carry nothing but the status
   a_trunc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_parse_status == STATUS_TRUNCATED) |->
         rsp_header_length == 5'd0 && rsp_version == 3'd0 && rsp_flag_bits == 5'd0
         && rsp_data_field_length == 16'd0 && rsp_source_entity == 64'd0
         && rsp_transaction_number == 64'd0 && rsp_dest_entity == 64'd0
         && !rsp_segmentation_control && !rsp_segment_metadata_flag
         && rsp_entity_length_code == 3'd0 && rsp_sequence_length_code == 3'd0)
      else $error("truncation result carries non-zero fields");

   // A byte is held off only behind a stalled result, and stays put while held
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid && rsp_stall
         ##1 (req_valid && $stable(req_data_byte) && $stable(req_last_byte)))
      else $error("byte input stalled without a stalled result, or held byte changed");

   // No result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind cfdp_pdu_header_parser cfdp_hdr_checker u_checker (.*);
